### rtl/bnps_pkg.sv
// Package for the buzzer note pattern sequencer: codes, payload structs,
// register file layout and the fixed note sequence tables.
// No dependencies; the design modules and the testbench import it.
package bnps_pkg;

  // Command codes carried in the func field.
  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_STOP  = 2'd2,
    FUNC_RAW   = 2'd3
  } func_e;

  // Action codes of a tone command.
  typedef enum logic [1:0] {
    ACT_NOTE   = 2'd0,
    ACT_RAW    = 2'd1,
    ACT_SILENT = 2'd2
  } action_e;

  localparam logic [3:0] NOTE_MEDIUM = 4'd7;
  localparam logic [3:0] NOTE_HIGH   = 4'd8;
  localparam logic [3:0] NOTE_MAX    = 4'd8;
  localparam logic [3:0] NOTE_REST   = 4'd15;

  localparam logic [3:0] PAT_CONT  = 4'd9;
  localparam logic [3:0] PAT_SIREN = 4'd10;

  // Step duration selectors.
  localparam logic [2:0] DUR_VS = 3'd0;
  localparam logic [2:0] DUR_S  = 3'd1;
  localparam logic [2:0] DUR_M  = 3'd2;
  localparam logic [2:0] DUR_L  = 3'd3;
  localparam logic [2:0] DUR_VL = 3'd4;
  localparam logic [2:0] DUR_P  = 3'd5;

  // Configuration register indexes.
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 16;
  typedef logic [CFG_AW-1:0] cfg_idx_t;
  typedef logic [CFG_DW-1:0] cfg_data_t;
  localparam cfg_idx_t CFG_VERY_SHORT = 3'd0;
  localparam cfg_idx_t CFG_SHORT      = 3'd1;
  localparam cfg_idx_t CFG_MEDIUM     = 3'd2;
  localparam cfg_idx_t CFG_LONG       = 3'd3;
  localparam cfg_idx_t CFG_VERY_LONG  = 3'd4;
  localparam cfg_idx_t CFG_PAUSE      = 3'd5;
  localparam cfg_idx_t CFG_SIREN      = 3'd6;
  localparam cfg_idx_t CFG_CONT_NOTE  = 3'd7;

  typedef struct packed {
    logic [15:0] dur_vs;
    logic [15:0] dur_s;
    logic [15:0] dur_m;
    logic [15:0] dur_l;
    logic [15:0] dur_vl;
    logic [15:0] pause;
    logic [15:0] siren;
    logic [3:0]  cont_note;
  } cfg_t;

  // One command word from the input channel.
  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  pattern;
    logic [31:0] duration_ms;
    logic [15:0] frequency;
  } cmd_t;

  // One tone command word for the output channel.
  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  note;
    logic [15:0] tone_freq;
    logic [15:0] tone_ms;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [3:0] note;
    logic [2:0] dur;
  } seq_step_t;

  // Result queue geometry.
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_AW    = 2;
  localparam int unsigned RQ_CW    = 3;

  function automatic logic [2:0] seq_len(input logic [3:0] pat);
    logic [2:0] n;
    case (pat)
      4'd0:    n = 3'd1;
      4'd1:    n = 3'd3;
      4'd2:    n = 3'd2;
      4'd3:    n = 3'd3;
      4'd4:    n = 3'd4;
      4'd5:    n = 3'd1;
      4'd6:    n = 3'd3;
      4'd7:    n = 3'd4;
      4'd8:    n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic seq_step_t seq_step(input logic [3:0] pat, input logic [1:0] idx);
    seq_step_t st;
    case ({pat, idx})
      {4'd0, 2'd0}: st = '{4'd3, DUR_VS};
      {4'd1, 2'd0}: st = '{4'd2, DUR_S};
      {4'd1, 2'd1}: st = '{NOTE_REST, DUR_P};
      {4'd1, 2'd2}: st = '{4'd3, DUR_S};
      {4'd2, 2'd0}: st = '{4'd2, DUR_VS};
      {4'd2, 2'd1}: st = '{4'd3, DUR_S};
      {4'd3, 2'd0}: st = '{4'd2, DUR_M};
      {4'd3, 2'd1}: st = '{4'd3, DUR_M};
      {4'd3, 2'd2}: st = '{4'd4, DUR_L};
      {4'd4, 2'd0}: st = '{4'd2, DUR_M};
      {4'd4, 2'd1}: st = '{4'd3, DUR_M};
      {4'd4, 2'd2}: st = '{4'd4, DUR_M};
      {4'd4, 2'd3}: st = '{4'd5, DUR_VL};
      {4'd5, 2'd0}: st = '{4'd6, DUR_VS};
      {4'd6, 2'd0}: st = '{4'd8, DUR_VS};
      {4'd6, 2'd1}: st = '{4'd7, DUR_VS};
      {4'd6, 2'd2}: st = '{4'd6, DUR_M};
      {4'd7, 2'd0}: st = '{4'd3, DUR_M};
      {4'd7, 2'd1}: st = '{4'd2, DUR_M};
      {4'd7, 2'd2}: st = '{4'd1, DUR_M};
      {4'd7, 2'd3}: st = '{4'd0, DUR_VL};
      {4'd8, 2'd0}: st = '{4'd1, DUR_VS};
      {4'd8, 2'd1}: st = '{4'd2, DUR_S};
      default:      st = '{NOTE_REST, DUR_VS};
    endcase
    return st;
  endfunction

  function automatic logic [15:0] dur_ms(input cfg_t c, input logic [2:0] code);
    logic [15:0] ms;
    case (code)
      DUR_VS:  ms = c.dur_vs;
      DUR_S:   ms = c.dur_s;
      DUR_M:   ms = c.dur_m;
      DUR_L:   ms = c.dur_l;
      DUR_VL:  ms = c.dur_vl;
      DUR_P:   ms = c.pause;
      default: ms = 16'd0;
    endcase
    return ms;
  endfunction

  function automatic result_t mk_result(input logic [1:0] act, input logic [3:0] note,
                                        input logic [15:0] freq, input logic [15:0] ms);
    result_t r;
    r.action    = act;
    r.note      = note;
    r.tone_freq = freq;
    r.tone_ms   = ms;
    r.last      = 1'b0;
    return r;
  endfunction

  // A rest step goes silent; any other step plays its note for its duration.
  function automatic result_t step_result(input cfg_t c, input seq_step_t st);
    result_t r;
    if (st.note == NOTE_REST) begin
      r = mk_result(ACT_SILENT, 4'd0, 16'd0, 16'd0);
    end else begin
      r = mk_result(ACT_NOTE, st.note, 16'd0, dur_ms(c, st.dur));
    end
    return r;
  endfunction

endpackage

### rtl/bnps_if.sv
// Valid/ready channel interfaces of the buzzer note pattern sequencer:
// the command input channel and the tone command output channel.
// No dependencies.
interface bnps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [3:0]  pattern;
  logic [31:0] duration_ms;
  logic [15:0] frequency;

  modport source (output valid, func, pattern, duration_ms, frequency, input ready);
  modport sink (input valid, func, pattern, duration_ms, frequency, output ready);
endinterface

interface bnps_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [3:0]  note;
  logic [15:0] tone_freq;
  logic [15:0] tone_ms;
  logic        last;

  modport source (output valid, action, note, tone_freq, tone_ms, last, input ready);
  modport sink (input valid, action, note, tone_freq, tone_ms, last, output ready);
endinterface

### rtl/buzzer_note_pattern_sequencer.sv
// Top level of the buzzer note pattern sequencer: register file, command
// decoder and result queue. Depends on bnps_pkg, bnps_if, bnps_cfg,
// bnps_core and bnps_resq.
//
// Usage: commands arrive as words on in_if (tick one millisecond, start a
// pattern, stop, or play a raw tone); tone commands for the tone generator
// leave as words on out_if, the final word of each command marked by last.
// Timing registers are written through cfg_we/cfg_addr/cfg_data; the user
// must write them only while the block is idle, which the block does not
// enforce; a write takes effect at the next edge. An accepted command's
// words enter the result queue; one command per cycle while room allows.
// A raw tone that interrupts a timed pattern yields two words.
// in_if.ready is high while the four-word result queue has at least two free
// slots, so a stalled receiver pushes back on the input once three or four
// words are waiting; no word is dropped. Synchronous reset restores the
// register defaults, stops any pattern and empties the queue.
module buzzer_note_pattern_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  bnps_in_if.sink             in_if,
  bnps_out_if.source          out_if,
  input  logic                cfg_we,
  input  bnps_pkg::cfg_idx_t  cfg_addr,
  input  bnps_pkg::cfg_data_t cfg_data
);
  import bnps_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  logic    accept;
  logic    room;
  logic [1:0] res_cnt;
  result_t res0;
  result_t res1;

  assign in_if.ready     = room;
  assign accept          = in_if.valid && room;
  assign cmd.func        = in_if.func;
  assign cmd.pattern     = in_if.pattern;
  assign cmd.duration_ms = in_if.duration_ms;
  assign cmd.frequency   = in_if.frequency;

  bnps_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  bnps_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .cmd     (cmd),
    .cfg     (cfg),
    .res_cnt (res_cnt),
    .res0    (res0),
    .res1    (res1)
  );

  bnps_resq u_resq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (accept),
    .wr_cnt (res_cnt),
    .wr0    (res0),
    .wr1    (res1),
    .room   (room),
    .out_if (out_if)
  );

endmodule

### rtl/bnps_cfg.sv
// Configuration register file of the buzzer note pattern sequencer.
// Depends on bnps_pkg for the register indexes and the cfg_t layout.
module bnps_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  bnps_pkg::cfg_idx_t  cfg_addr,
  input  bnps_pkg::cfg_data_t cfg_data,
  output bnps_pkg::cfg_t      cfg
);
  import bnps_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dur_vs    <= 16'd50;
      cfg_r.dur_s     <= 16'd100;
      cfg_r.dur_m     <= 16'd200;
      cfg_r.dur_l     <= 16'd400;
      cfg_r.dur_vl    <= 16'd800;
      cfg_r.pause     <= 16'd50;
      cfg_r.siren     <= 16'd300;
      cfg_r.cont_note <= 4'd7;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_VERY_SHORT: cfg_r.dur_vs    <= cfg_data;
        CFG_SHORT:      cfg_r.dur_s     <= cfg_data;
        CFG_MEDIUM:     cfg_r.dur_m     <= cfg_data;
        CFG_LONG:       cfg_r.dur_l     <= cfg_data;
        CFG_VERY_LONG:  cfg_r.dur_vl    <= cfg_data;
        CFG_PAUSE:      cfg_r.pause     <= cfg_data;
        CFG_SIREN:      cfg_r.siren     <= cfg_data;
        CFG_CONT_NOTE:  cfg_r.cont_note <= cfg_data[3:0];
        default:        cfg_r           <= cfg_r;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/bnps_core.sv
// Command decoder and pattern state of the buzzer note pattern sequencer.
// Turns one accepted command into up to two tone words combinationally.
// Depends on bnps_pkg for codes, tables and payload structs.
module bnps_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  bnps_pkg::cmd_t    cmd,
  input  bnps_pkg::cfg_t    cfg,
  output logic [1:0]        res_cnt,
  output bnps_pkg::result_t res0,
  output bnps_pkg::result_t res1
);
  import bnps_pkg::*;

  logic        active_r, active_nxt;
  logic [3:0]  pat_r, pat_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] tip_r, tip_nxt;
  logic [31:0] tis_r, tis_nxt;

  logic [31:0] tip_inc;
  logic [31:0] tis_inc;
  logic [2:0]  step_m1;
  logic [2:0]  seq_n;
  seq_step_t   prev_st;
  seq_step_t   cur_st;
  seq_step_t   first_st;
  logic [15:0] raw_ms;
  logic [3:0]  cont_note;
  logic [1:0]  cnt;
  result_t     r0;
  result_t     r1;

  assign tip_inc  = tip_r + 32'd1;
  assign tis_inc  = tis_r + 32'd1;
  assign step_m1  = step_r - 3'd1;
  assign seq_n    = seq_len(pat_r);
  assign first_st = seq_step(pat_r, 2'd0);
  assign prev_st  = seq_step(pat_r, step_m1[1:0]);
  assign cur_st   = seq_step(pat_r, step_r[1:0]);
  assign raw_ms   = (|cmd.duration_ms[31:16]) ? 16'hFFFF : cmd.duration_ms[15:0];
  assign cont_note = (cfg.cont_note > NOTE_MAX) ? NOTE_MAX : cfg.cont_note;

  always_comb begin
    active_nxt = active_r;
    pat_nxt    = pat_r;
    step_nxt   = step_r;
    len_nxt    = len_r;
    tip_nxt    = tip_r;
    tis_nxt    = tis_r;
    cnt        = 2'd0;
    r0         = '0;
    r1         = '0;
    if (accept) begin
      case (cmd.func)
        FUNC_TICK: begin
          if (active_r && (len_r != 32'd0)) begin
            tip_nxt = tip_inc;
            tis_nxt = tis_inc;
            if (tip_inc >= len_r) begin
              active_nxt = 1'b0;
              step_nxt   = 3'd0;
              len_nxt    = 32'd0;
              r0         = mk_result(ACT_SILENT, 4'd0, 16'd0, 16'd0);
              cnt        = 2'd1;
            end else if (pat_r < PAT_CONT) begin
              if (step_r == 3'd0) begin
                r0       = step_result(cfg, first_st);
                step_nxt = 3'd1;
                tis_nxt  = 32'd0;
                cnt      = 2'd1;
              end else if ((step_r <= seq_n) &&
                           (tis_inc >= {16'd0, dur_ms(cfg, prev_st.dur)})) begin
                // The previous step has run its length: play the next or finish.
                if (step_r < seq_n) begin
                  r0       = step_result(cfg, cur_st);
                  step_nxt = step_r + 3'd1;
                  tis_nxt  = 32'd0;
                end else begin
                  active_nxt = 1'b0;
                  step_nxt   = 3'd0;
                  len_nxt    = 32'd0;
                  r0         = mk_result(ACT_SILENT, 4'd0, 16'd0, 16'd0);
                end
                cnt = 2'd1;
              end
            end else if ((pat_r == PAT_SIREN) && (tis_inc >= {16'd0, cfg.siren})) begin
              if (step_r == 3'd0) begin
                r0       = mk_result(ACT_NOTE, NOTE_HIGH, 16'd0, 16'd0);
                step_nxt = 3'd1;
              end else begin
                r0       = mk_result(ACT_NOTE, NOTE_MEDIUM, 16'd0, 16'd0);
                step_nxt = 3'd0;
              end
              tis_nxt = 32'd0;
              cnt     = 2'd1;
            end
          end
        end
        FUNC_START: begin
          pat_nxt    = cmd.pattern;
          step_nxt   = 3'd0;
          tip_nxt    = 32'd0;
          tis_nxt    = 32'd0;
          len_nxt    = cmd.duration_ms;
          active_nxt = 1'b1;
          if (cmd.pattern == PAT_CONT) begin
            r0  = mk_result(ACT_NOTE, cont_note, 16'd0, 16'd0);
            cnt = 2'd1;
          end else if (cmd.pattern == PAT_SIREN) begin
            r0  = mk_result(ACT_NOTE, NOTE_MEDIUM, 16'd0, 16'd0);
            cnt = 2'd1;
          end
        end
        FUNC_STOP: begin
          active_nxt = 1'b0;
          step_nxt   = 3'd0;
          len_nxt    = 32'd0;
          r0         = mk_result(ACT_SILENT, 4'd0, 16'd0, 16'd0);
          cnt        = 2'd1;
        end
        default: begin
          // Raw tone: a running timed pattern is silenced first.
          active_nxt = 1'b1;
          step_nxt   = 3'd0;
          len_nxt    = 32'd0;
          if (len_r != 32'd0) begin
            r0  = mk_result(ACT_SILENT, 4'd0, 16'd0, 16'd0);
            r1  = mk_result(ACT_RAW, 4'd0, cmd.frequency, raw_ms);
            cnt = 2'd2;
          end else begin
            r0  = mk_result(ACT_RAW, 4'd0, cmd.frequency, raw_ms);
            cnt = 2'd1;
          end
        end
      endcase
    end
    if (cnt == 2'd1) begin
      r0.last = 1'b1;
    end
    if (cnt == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pat_r    <= 4'd0;
      step_r   <= 3'd0;
      len_r    <= 32'd0;
      tip_r    <= 32'd0;
      tis_r    <= 32'd0;
    end else begin
      active_r <= active_nxt;
      pat_r    <= pat_nxt;
      step_r   <= step_nxt;
      len_r    <= len_nxt;
      tip_r    <= tip_nxt;
      tis_r    <= tis_nxt;
    end
  end

  assign res_cnt = cnt;
  assign res0    = r0;
  assign res1    = r1;

`ifndef ASSERT_OFF
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (step_r == 3'd0 && len_r == 32'd0))
    else $error("inactive sequencer holds a step or a length");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && pat_r < PAT_CONT) |-> (step_r <= seq_len(pat_r)))
    else $error("step index beyond the pattern length");

  a_two_words_raw: assert property (@(posedge clk) disable iff (!rst_n)
    (res_cnt == 2'd2) |-> (accept && cmd.func == FUNC_RAW && res0.action == ACT_SILENT))
    else $error("two words produced by something other than a raw tone");

  a_tick_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && cmd.func == FUNC_TICK && len_r == 32'd0) |=> $stable(tip_r))
    else $error("pattern timer advanced without a length");
`endif

endmodule

### rtl/bnps_resq.sv
// Four-word result queue of the buzzer note pattern sequencer. Takes up to
// two words per cycle from the decoder and drives the output channel.
// Depends on bnps_pkg and the bnps_out_if interface.
module bnps_resq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [1:0]        wr_cnt,
  input  bnps_pkg::result_t wr0,
  input  bnps_pkg::result_t wr1,
  output logic              room,
  bnps_out_if.source        out_if
);
  import bnps_pkg::*;

  result_t              mem_r [RQ_DEPTH];
  logic [RQ_AW-1:0]     wp_r, wp_nxt;
  logic [RQ_AW-1:0]     rp_r, rp_nxt;
  logic [RQ_CW-1:0]     count_r, count_nxt;
  logic [RQ_AW-1:0]     wp_p1;
  logic [RQ_CW-1:0]     add;
  logic                 pop;
  result_t              head;

  assign wp_p1 = wp_r + 1'b1;
  assign add   = push ? {1'b0, wr_cnt} : '0;
  assign pop   = out_if.valid && out_if.ready;

  // Room for the worst case of two words from one command.
  assign room = (count_r <= RQ_CW'(RQ_DEPTH - 2));

  always_comb begin
    wp_nxt    = wp_r + add[RQ_AW-1:0];
    rp_nxt    = pop ? rp_r + 1'b1 : rp_r;
    count_nxt = count_r + add - (pop ? RQ_CW'(1) : RQ_CW'(0));
  end

  always_ff @(posedge clk) begin
    if (push && wr_cnt != 2'd0) begin
      mem_r[wp_r] <= wr0;
    end
    if (push && wr_cnt == 2'd2) begin
      mem_r[wp_p1] <= wr1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
    end
  end

  assign head             = mem_r[rp_r];
  assign out_if.valid     = (count_r != '0);
  assign out_if.action    = head.action;
  assign out_if.note      = head.note;
  assign out_if.tone_freq = head.tone_freq;
  assign out_if.tone_ms   = head.tone_ms;
  assign out_if.last      = head.last;

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= RQ_CW'(RQ_DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push && wr_cnt != 2'd0) |-> room)
    else $error("words pushed without room");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !(push && wr_cnt != 2'd0)) |=> (count_r == $past(count_r) - RQ_CW'(1)))
    else $error("queue count did not drop on a pop");
`endif

endmodule

### tb/tb_buzzer_note_pattern_sequencer.sv
// Self-checking testbench for buzzer_note_pattern_sequencer: drives command
// words, predicts the tone command words in a model of its own and checks them.
// Depends on bnps_pkg, the bnps_in_if/bnps_out_if interfaces and the RTL.
module tb_buzzer_note_pattern_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import bnps_pkg::*;

  localparam logic [3:0] PAT_BEEP   = 4'd0;
  localparam logic [3:0] PAT_SELECT = 4'd1;
  localparam logic [3:0] PAT_GOLD   = 4'd2;
  localparam logic [3:0] PAT_LEVEL  = 4'd3;
  localparam logic [3:0] PAT_WON    = 4'd4;
  localparam logic [3:0] PAT_WALL   = 4'd5;
  localparam logic [3:0] PAT_BOMB   = 4'd6;
  localparam logic [3:0] PAT_OVER   = 4'd7;
  localparam logic [3:0] PAT_ROOM   = 4'd8;
  localparam logic [3:0] PAT_UNUSED = 4'd15;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS   = 315;

  // Step k of a melody lives in bits 4k+3:4k of notes and durs.
  typedef struct packed {
    logic [2:0]  steps;
    logic [15:0] durs;
    logic [15:0] notes;
  } melody_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_addr;
  cfg_data_t cfg_data;

  bnps_in_if  in_ch ();
  bnps_out_if out_ch ();

  buzzer_note_pattern_sequencer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  // Shadow of the register file and of the sequencer state.
  logic [15:0] reg_shadow [8];
  logic        run_active;
  logic [3:0]  run_pat;
  logic [2:0]  run_step;
  logic [31:0] run_len;
  logic [31:0] ms_in_pattern;
  logic [31:0] ms_in_step;

  cmd_t    cmds_pending [$];
  result_t tone_words_due [$];
  int      cmds_queued;
  int      cmds_taken;
  int      fail_count;
  int      cycle_count;

  function automatic melody_t melody(input logic [3:0] pat);
    melody_t m;
    case (pat)
      PAT_BEEP:   m = {3'd1, 16'h0000, 16'h0003};
      PAT_SELECT: m = {3'd3, 16'h0151, 16'h03F2};
      PAT_GOLD:   m = {3'd2, 16'h0010, 16'h0032};
      PAT_LEVEL:  m = {3'd3, 16'h0322, 16'h0432};
      PAT_WON:    m = {3'd4, 16'h4222, 16'h5432};
      PAT_WALL:   m = {3'd1, 16'h0000, 16'h0006};
      PAT_BOMB:   m = {3'd3, 16'h0200, 16'h0678};
      PAT_OVER:   m = {3'd4, 16'h4222, 16'h0123};
      PAT_ROOM:   m = {3'd2, 16'h0010, 16'h0021};
      default:    m = '0;
    endcase
    return m;
  endfunction

  function automatic result_t tone_word(input logic [1:0] act, input logic [3:0] nt,
                                        input logic [15:0] freq, input logic [15:0] ms);
    result_t w;
    w.action    = act;
    w.note      = nt;
    w.tone_freq = freq;
    w.tone_ms   = ms;
    w.last      = 1'b0;
    return w;
  endfunction

  function automatic logic [15:0] step_ms(input melody_t m, input int idx);
    logic [15:0] sel;
    sel = m.durs >> (4 * idx);
    return reg_shadow[sel[2:0]];
  endfunction

  // The select pattern's gap is a rest: it goes silent but keeps the run alive.
  function automatic result_t step_word(input melody_t m, input int idx);
    logic [15:0] nt;
    nt = m.notes >> (4 * idx);
    if (nt[3:0] == NOTE_REST) return tone_word(ACT_SILENT, 4'd0, 16'd0, 16'd0);
    return tone_word(ACT_NOTE, nt[3:0], 16'd0, step_ms(m, idx));
  endfunction

  task automatic stop_run();
    run_active = 1'b0;
    run_step   = 3'd0;
    run_len    = 32'd0;
  endtask

  task automatic predict_tone_words(input cmd_t c);
    result_t w [2];
    int      n;
    melody_t m;
    logic [3:0] nt;
    n = 0;
    case (c.func)
      FUNC_TICK: begin
        if (run_active && run_len != 32'd0) begin
          ms_in_pattern = ms_in_pattern + 32'd1;
          ms_in_step    = ms_in_step + 32'd1;
          if (ms_in_pattern >= run_len) begin
            stop_run();
            w[n++] = tone_word(ACT_SILENT, 4'd0, 16'd0, 16'd0);
          end else if (run_pat < PAT_CONT) begin
            m = melody(run_pat);
            if (run_step == 3'd0) begin
              w[n++] = step_word(m, 0);
              run_step   = 3'd1;
              ms_in_step = 32'd0;
            end else if (run_step <= m.steps &&
                         ms_in_step >= {16'd0, step_ms(m, int'(run_step) - 1)}) begin
              if (run_step < m.steps) begin
                w[n++] = step_word(m, int'(run_step));
                run_step   = run_step + 3'd1;
                ms_in_step = 32'd0;
              end else begin
                stop_run();
                w[n++] = tone_word(ACT_SILENT, 4'd0, 16'd0, 16'd0);
              end
            end
          end else if (run_pat == PAT_SIREN &&
                       ms_in_step >= {16'd0, reg_shadow[CFG_SIREN]}) begin
            w[n++] = tone_word(ACT_NOTE, (run_step == 3'd0) ? NOTE_HIGH : NOTE_MEDIUM,
                               16'd0, 16'd0);
            run_step   = (run_step == 3'd0) ? 3'd1 : 3'd0;
            ms_in_step = 32'd0;
          end
        end
      end
      FUNC_START: begin
        run_pat       = c.pattern;
        run_step      = 3'd0;
        ms_in_pattern = 32'd0;
        ms_in_step    = 32'd0;
        run_len       = c.duration_ms;
        run_active    = 1'b1;
        if (c.pattern == PAT_CONT) begin
          nt = reg_shadow[CFG_CONT_NOTE][3:0];
          if (nt > NOTE_MAX) nt = NOTE_MAX;
          w[n++] = tone_word(ACT_NOTE, nt, 16'd0, 16'd0);
        end else if (c.pattern == PAT_SIREN) begin
          w[n++] = tone_word(ACT_NOTE, NOTE_MEDIUM, 16'd0, 16'd0);
        end
      end
      FUNC_STOP: begin
        stop_run();
        w[n++] = tone_word(ACT_SILENT, 4'd0, 16'd0, 16'd0);
      end
      default: begin
        // A raw tone cuts a timed pattern short with a silence word first.
        if (run_len != 32'd0) w[n++] = tone_word(ACT_SILENT, 4'd0, 16'd0, 16'd0);
        stop_run();
        run_active = 1'b1;
        w[n++] = tone_word(ACT_RAW, 4'd0, c.frequency,
                           (c.duration_ms > 32'h0000FFFF) ? 16'hFFFF : c.duration_ms[15:0]);
      end
    endcase
    if (n > 0) w[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) tone_words_due.push_back(w[i]);
  endtask

  // Sender: bursts of random length separated by random gaps.
  cmd_t cmd_on_bus;
  int   burst_left;
  int   gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_tone_words(cmd_on_bus);
        cmds_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (cmds_pending.size() > 0) begin
          cmd_on_bus = cmds_pending.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.func        <= cmd_on_bus.func;
          in_ch.pattern     <= cmd_on_bus.pattern;
          in_ch.duration_ms <= cmd_on_bus.duration_ms;
          in_ch.frequency   <= cmd_on_bus.frequency;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic report(input string field, input logic [31:0] exp_v,
                        input logic [31:0] act_v);
    if (fail_count < 40) $error("%s: expected %0d, actual %0d", field, exp_v, act_v);
    fail_count++;
  endtask

  // Receiver: ready follows a rotating stall mask that is redrawn now and then.
  logic [15:0] stall_mask;
  int          stall_pos;
  result_t     want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_mask = 16'hFFFF;
      stall_pos  = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (tone_words_due.size() == 0) begin
          if (fail_count < 40) $error("tone word arrived with none expected");
          fail_count++;
        end else begin
          want = tone_words_due.pop_front();
          if (out_ch.action !== want.action) report("action", want.action, out_ch.action);
          if (out_ch.note !== want.note) report("note", want.note, out_ch.note);
          if (out_ch.tone_freq !== want.tone_freq)
            report("tone_freq", want.tone_freq, out_ch.tone_freq);
          if (out_ch.tone_ms !== want.tone_ms) report("tone_ms", want.tone_ms, out_ch.tone_ms);
          if (out_ch.last !== want.last) report("last", want.last, out_ch.last);
        end
      end
      out_ch.ready <= stall_mask[stall_pos];
      stall_pos++;
      if (stall_pos == 16) begin
        stall_pos  = 0;
        stall_mask = ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                 : (16'($urandom) | 16'h0001);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic queue_cmd(input logic [1:0] func, input logic [3:0] pat,
                           input logic [31:0] dur, input logic [15:0] freq);
    cmd_t c;
    c.func        = func;
    c.pattern     = pat;
    c.duration_ms = dur;
    c.frequency   = freq;
    cmds_pending.push_back(c);
    cmds_queued++;
  endtask

  task automatic queue_tick();
    queue_cmd(FUNC_TICK, 4'($urandom_range(0, 15)), $urandom, 16'($urandom_range(0, 65535)));
  endtask

  function automatic logic [31:0] raw_length();
    case ($urandom_range(0, 4))
      0:       return $urandom;
      1:       return 32'h0000FFFF;
      2:       return 32'h00010000;
      3:       return 32'd0;
      default: return $urandom_range(1, 1000);
    endcase
  endfunction

  // Mostly whole runs: a start, a train of ticks, then a stop, a raw tone or
  // nothing; the rest is noise.
  task automatic queue_random_phase(input int tick_max);
    int goal;
    int ticks;
    logic [3:0] pat;
    logic [31:0] len;
    goal = cmds_queued + PHASE_ITEMS;
    while (cmds_queued < goal) begin
      if ($urandom_range(0, 7) == 0) begin
        queue_cmd(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), $urandom,
                  16'($urandom_range(0, 65535)));
      end else begin
        pat = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(11, 15))
                                          : 4'($urandom_range(0, 10));
        case ($urandom_range(0, 9))
          0:       len = 32'd0;
          1:       len = 32'hFFFFFFFF;
          2:       len = $urandom;
          default: len = $urandom_range(1, 3 * tick_max);
        endcase
        queue_cmd(FUNC_START, pat, len, 16'($urandom_range(0, 65535)));
        ticks = $urandom_range(1, tick_max);
        repeat (ticks) queue_tick();
        case ($urandom_range(0, 3))
          0: queue_cmd(FUNC_STOP, 4'($urandom_range(0, 15)), $urandom,
                       16'($urandom_range(0, 65535)));
          1: queue_cmd(FUNC_RAW, 4'($urandom_range(0, 15)), raw_length(),
                       16'($urandom_range(0, 65535)));
          default: ;
        endcase
      end
    end
  endtask

  task automatic wait_idle();
    while (cmds_taken != cmds_queued || tone_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] cfg_value(input int ph, input int idx);
    if (idx == CFG_CONT_NOTE) begin
      case (ph)
        2:       return 16'd0;
        3:       return 16'd15;
        4:       return 16'($urandom_range(8, 15));
        default: return 16'($urandom_range(0, 15));
      endcase
    end
    case (ph)
      1:       return 16'($urandom_range(1, 4));
      2:       return 16'd1;
      3:       return 16'hFFFF;
      4:       return 16'($urandom_range(0, 2));
      default: return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    reg_shadow[idx] = (idx == CFG_CONT_NOTE) ? (val & 16'h000F) : val;
    @(posedge clk);
  endtask

  initial begin
    int tick_max [6];
    clk   = 1'b0;
    rst_n = 1'b0;
    cfg_we   = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    in_ch.valid       = 1'b0;
    in_ch.func        = '0;
    in_ch.pattern     = '0;
    in_ch.duration_ms = '0;
    in_ch.frequency   = '0;
    out_ch.ready      = 1'b0;
    cmds_queued = 0;
    cmds_taken  = 0;
    fail_count  = 0;
    cycle_count = 0;
    tick_max = '{0, 30, 20, 10, 20, 30};
    reg_shadow = '{16'd50, 16'd100, 16'd200, 16'd400, 16'd800, 16'd50, 16'd300, 16'd7};
    run_active    = 1'b0;
    run_pat       = PAT_BEEP;
    stop_run();
    ms_in_pattern = 32'd0;
    ms_in_step    = 32'd0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the register defaults.
    queue_tick();
    queue_cmd(FUNC_START, PAT_BEEP, 32'd3, 16'd0);
    repeat (3) queue_tick();
    queue_cmd(FUNC_START, PAT_CONT, 32'd0, 16'd0);
    queue_tick();
    queue_cmd(FUNC_START, PAT_SIREN, 32'd0, 16'd0);
    queue_cmd(FUNC_STOP, PAT_BEEP, 32'd0, 16'd0);
    queue_cmd(FUNC_RAW, PAT_BEEP, 32'hFFFFFFFF, 16'hFFFF);
    queue_cmd(FUNC_START, PAT_GOLD, 32'hFFFFFFFF, 16'd0);
    queue_tick();
    queue_cmd(FUNC_RAW, PAT_BEEP, 32'd0, 16'd0);
    queue_cmd(FUNC_START, PAT_UNUSED, 32'd2, 16'd0);
    repeat (2) queue_tick();
    queue_cmd(FUNC_START, PAT_SIREN, 32'd2, 16'd0);
    repeat (2) queue_tick();
    queue_cmd(FUNC_RAW, PAT_SELECT, 32'h00010000, 16'd1234);
    queue_cmd(FUNC_RAW, PAT_WON, 32'h0000FFFF, 16'd440);
    wait_idle();

    for (int ph = 1; ph <= 5; ph++) begin
      for (int idx = 0; idx < 8; idx++) write_reg(cfg_idx_t'(idx), cfg_value(ph, idx));
      cfg_we <= 1'b0;
      queue_random_phase(tick_max[ph]);
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0 && tone_words_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### buzzer_note_pattern_sequencer.f
rtl/bnps_pkg.sv
rtl/bnps_if.sv
rtl/bnps_cfg.sv
rtl/bnps_core.sv
rtl/bnps_resq.sv
rtl/buzzer_note_pattern_sequencer.sv
tb/tb_buzzer_note_pattern_sequencer.sv
